// ----- rtl/core/apfr_pkg.sv -----
`default_nettype none

package apfr_pkg;

  // Command carried on the input channel's tuser.
  typedef enum logic [1:0] {
    FUNC_BYTE = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NOP  = 2'd3
  } apfr_func_t;

  // Per-beat frame outcome.
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_ACCEPT  = 2'd1,
    EV_BADSUM  = 2'd2,
    EV_OVERRUN = 2'd3
  } apfr_event_t;

  // Receive state: hunting for a delimiter, in a frame, or after an escape byte.
  typedef enum logic [1:0] {
    RX_HUNT = 2'd0,
    RX_BODY = 2'd1,
    RX_ESC  = 2'd2
  } apfr_rx_state_t;

  localparam logic [7:0] DELIM_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] ESC_XOR    = 8'h20;
  localparam logic [7:0] SUM_OK     = 8'hFF;
  localparam logic [7:0] ID_TYPE_A  = 8'h80;
  localparam logic [7:0] ID_TYPE_B  = 8'h81;
  localparam logic [7:0] OVH_TYPE_A = 8'd11;
  localparam logic [7:0] OVH_TYPE_B = 8'd5;

  // Depth of the queue between front and back.
  localparam int Q_DEPTH = 4;

  // Result fields other than the two slot numbers: 8+1+1+2+8+16+8+8+9+8.
  localparam int OUT_FIXED_W = 69;

  // Slot header bytes one to five, kept beside the packet memory.
  typedef struct packed {
    logic [7:0] len;
    logic [7:0] id;
    logic [7:0] addr_hi;
    logic [7:0] addr_lo;
    logic [7:0] rssi;
  } apfr_hdr_t;

  // What the front hands to the back for one beat.
  typedef struct packed {
    logic [7:0]  read_data;
    logic        pkt_ready;
    logic        ring_full;
    apfr_event_t frame_event;
    apfr_hdr_t   hdr;
    logic [7:0]  running_sum;
  } apfr_info_t;

  function automatic int out_width(input int sw);
    return ((OUT_FIXED_W + 2 * sw + 7) / 8) * 8;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/apfr_front.sv -----
`default_nettype none

module apfr_front #(
  parameter int SLOT_BYTES = 128,
  parameter int SLOT_COUNT = 4,
  localparam int SW = $clog2(SLOT_COUNT),
  localparam int IDX_W = $clog2(SLOT_BYTES)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire apfr_pkg::apfr_func_t  func,
  input  wire logic [7:0]            rx_byte,
  input  wire logic [6:0]            read_index,
  input  wire logic                  q_afull,
  output logic                       b_valid,
  output apfr_pkg::apfr_info_t       b_info,
  output logic [SW-1:0]              b_fill_slot,
  output logic [SW-1:0]              b_head_slot
);
  import apfr_pkg::*;

  localparam int MEM_DEPTH = SLOT_BYTES * SLOT_COUNT;
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
  endfunction

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] mem_q_r;

  apfr_rx_state_t rx_state_r, rx_state_nxt;
  logic [IDX_W-1:0] byte_idx_r, byte_idx_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [SW-1:0] fill_r, fill_nxt;
  logic [SW-1:0] head_r, head_nxt;
  logic full_r, full_nxt;
  logic ready_r, ready_nxt;
  apfr_hdr_t hdr_r [SLOT_COUNT];

  logic b_valid_r;
  logic b_rd_ok_r;
  apfr_info_t b_info_r;
  logic [SW-1:0] b_fill_r, b_head_r;

  logic acc, is_byte, is_pop, is_read, live, is_delim, is_esc;
  logic store, in_sum, at_check, commit, overrun, frame_end, hdr_we, rd_ok;
  logic [7:0] data_byte, sum_add;
  apfr_event_t ev;
  apfr_hdr_t hdr_view;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  assign in_ready = !q_afull;
  assign acc      = in_valid && in_ready;
  assign is_byte  = acc && (func == FUNC_BYTE);
  assign is_pop   = acc && (func == FUNC_POP);
  assign is_read  = acc && (func == FUNC_READ);
  assign live     = is_byte && !full_r;
  assign is_delim = (rx_byte == DELIM_BYTE);
  assign is_esc   = (rx_byte == ESC_BYTE);

  // Datapath decisions for the current beat.
  always_comb begin
    store     = live && !is_delim && !is_esc &&
                (rx_state_r == RX_BODY || rx_state_r == RX_ESC);
    data_byte = (rx_state_r == RX_ESC) ? (rx_byte ^ ESC_XOR) : rx_byte;
    sum_add   = sum_r + data_byte;
    in_sum    = (byte_idx_r > IDX_W'(1));
    at_check  = store && in_sum && (9'(byte_idx_r) == ({1'b0, len_r} + 9'd2));
    commit    = at_check && (sum_add == SUM_OK);
    overrun   = store && !at_check && (byte_idx_r == IDX_W'(SLOT_BYTES - 1));
    frame_end = at_check || overrun;
    hdr_we    = store && (byte_idx_r >= IDX_W'(1)) && (byte_idx_r <= IDX_W'(5));

    if (commit) begin
      ev = EV_ACCEPT;
    end else if (at_check) begin
      ev = EV_BADSUM;
    end else if (overrun) begin
      ev = EV_OVERRUN;
    end else begin
      ev = EV_NONE;
    end
  end

  // Receive state transitions.
  always_comb begin
    rx_state_nxt = rx_state_r;
    if (live) begin
      if (is_delim) begin
        rx_state_nxt = RX_BODY;
      end else begin
        case (rx_state_r)
          RX_HUNT: rx_state_nxt = RX_HUNT;
          RX_BODY, RX_ESC: begin
            if (is_esc) begin
              rx_state_nxt = RX_ESC;
            end else if (frame_end) begin
              rx_state_nxt = RX_HUNT;
            end else begin
              rx_state_nxt = RX_BODY;
            end
          end
          default: rx_state_nxt = RX_HUNT;
        endcase
      end
    end
  end

  // Ring and frame counters.
  always_comb begin
    byte_idx_nxt = byte_idx_r;
    sum_nxt      = sum_r;
    len_nxt      = len_r;
    fill_nxt     = fill_r;
    head_nxt     = head_r;
    full_nxt     = full_r;
    ready_nxt    = ready_r;

    if (live && is_delim) begin
      byte_idx_nxt = '0;
      sum_nxt      = '0;
    end else if (store) begin
      if (!frame_end) begin
        byte_idx_nxt = byte_idx_r + 1'b1;
      end
      if (in_sum) begin
        sum_nxt = sum_add;
      end
      if (byte_idx_r == IDX_W'(1)) begin
        len_nxt = data_byte;
      end
    end

    if (commit) begin
      fill_nxt  = slot_inc(fill_r);
      full_nxt  = (slot_inc(fill_r) == head_r);
      ready_nxt = 1'b1;
    end

    if (is_pop) begin
      if (full_r || head_r != fill_r) begin
        head_nxt = slot_inc(head_r);
      end
      if (head_nxt == fill_r) begin
        ready_nxt = 1'b0;
      end
      full_nxt = 1'b0;
    end
  end

  // Head header after this beat, including a header byte written right now.
  always_comb begin
    hdr_view = hdr_r[head_nxt];
    if (hdr_we && fill_r == head_nxt) begin
      case (byte_idx_r)
        IDX_W'(1): hdr_view.len     = data_byte;
        IDX_W'(2): hdr_view.id      = data_byte;
        IDX_W'(3): hdr_view.addr_hi = data_byte;
        IDX_W'(4): hdr_view.addr_lo = data_byte;
        IDX_W'(5): hdr_view.rssi    = data_byte;
        default:   hdr_view = hdr_r[head_nxt];
      endcase
    end
  end

  assign rd_ok = is_read && ready_r &&
                 ({2'b0, read_index} < 9'(SLOT_BYTES)) &&
                 ({2'b0, read_index} <= ({1'b0, hdr_view.len} + 9'd2));

  assign wr_addr = ADDR_W'(fill_r) * ADDR_W'(SLOT_BYTES) + ADDR_W'(byte_idx_r);
  assign rd_addr = ADDR_W'(head_r) * ADDR_W'(SLOT_BYTES) + ADDR_W'(read_index);

  always_ff @(posedge clk) begin
    if (store) begin
      mem[wr_addr] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (is_read) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      case (byte_idx_r)
        IDX_W'(1): hdr_r[fill_r].len     <= data_byte;
        IDX_W'(2): hdr_r[fill_r].id      <= data_byte;
        IDX_W'(3): hdr_r[fill_r].addr_hi <= data_byte;
        IDX_W'(4): hdr_r[fill_r].addr_lo <= data_byte;
        IDX_W'(5): hdr_r[fill_r].rssi    <= data_byte;
        default:   hdr_r[fill_r].rssi    <= hdr_r[fill_r].rssi;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_state_r <= RX_HUNT;
      byte_idx_r <= '0;
      len_r      <= '0;
      sum_r      <= '0;
      fill_r     <= '0;
      head_r     <= '0;
      full_r     <= 1'b0;
      ready_r    <= 1'b0;
      b_valid_r  <= 1'b0;
    end else begin
      rx_state_r <= rx_state_nxt;
      byte_idx_r <= byte_idx_nxt;
      len_r      <= len_nxt;
      sum_r      <= sum_nxt;
      fill_r     <= fill_nxt;
      head_r     <= head_nxt;
      full_r     <= full_nxt;
      ready_r    <= ready_nxt;
      b_valid_r  <= acc;
    end
  end

  // Register the beat's result while the memory read completes.
  always_ff @(posedge clk) begin
    if (acc) begin
      b_rd_ok_r                <= rd_ok;
      b_info_r.read_data       <= '0;
      b_info_r.pkt_ready       <= ready_nxt;
      b_info_r.ring_full       <= full_nxt;
      b_info_r.frame_event     <= ev;
      b_info_r.hdr             <= hdr_view;
      b_info_r.running_sum     <= sum_nxt;
      b_fill_r                 <= fill_nxt;
      b_head_r                 <= head_nxt;
    end
  end

  always_comb begin
    b_info           = b_info_r;
    b_info.read_data = b_rd_ok_r ? mem_q_r : 8'd0;
  end

  assign b_valid     = b_valid_r;
  assign b_fill_slot = b_fill_r;
  assign b_head_slot = b_head_r;

endmodule

`default_nettype wire

// ----- rtl/core/apfr_fifo.sv -----
`default_nettype none

module apfr_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 4,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  input  wire logic         pop,
  output logic              valid,
  output logic [W-1:0]      rdata,
  output logic              afull
);

  logic [W-1:0] ent_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign valid = (count_r != '0);
  assign rdata = ent_r[rd_ptr_r];
  // Keep room for the beat in flight.
  assign afull = (count_r > CNT_W'(DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/apfr_back.sv -----
`default_nettype none

module apfr_back #(
  parameter int SW = 2,
  localparam int OUT_W = apfr_pkg::out_width(SW)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  input  wire apfr_pkg::apfr_info_t  q_info,
  input  wire logic [SW-1:0]         q_fill_slot,
  input  wire logic [SW-1:0]         q_head_slot,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OUT_W-1:0]           out_data
);
  import apfr_pkg::*;

  logic out_valid_r;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic [7:0] len, id, addr_hi, addr_lo, rssi, dlen;
  logic [8:0] plen;
  logic pr;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  // Decode the head header; bytes beyond the packet read as zero.
  always_comb begin
    pr      = q_info.pkt_ready;
    len     = pr ? q_info.hdr.len : 8'd0;
    id      = pr ? q_info.hdr.id : 8'd0;
    addr_hi = (pr && len >= 8'd1) ? q_info.hdr.addr_hi : 8'd0;
    addr_lo = (pr && len >= 8'd2) ? q_info.hdr.addr_lo : 8'd0;
    rssi    = (pr && len >= 8'd3) ? q_info.hdr.rssi : 8'd0;
    plen    = pr ? ({1'b0, len} + 9'd3) : 9'd0;
    if (pr && id == ID_TYPE_A) begin
      dlen = (len > OVH_TYPE_A) ? (len - OVH_TYPE_A) : 8'd0;
    end else if (pr && id == ID_TYPE_B) begin
      dlen = (len > OVH_TYPE_B) ? (len - OVH_TYPE_B) : 8'd0;
    end else begin
      dlen = 8'd0;
    end
    out_data_nxt = OUT_W'({q_info.running_sum, q_head_slot, q_fill_slot, plen, dlen,
                           rssi, addr_hi, addr_lo, id, q_info.frame_event,
                           q_info.ring_full, q_info.pkt_ready, q_info.read_data});
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/api_frame_receiver_packet_ring.sv -----
// Receive deframer for escaped API frames with a ring of packet slots.
// Input channel (in_*): one beat per command. in_tuser selects the command:
// received serial byte, pop the head packet, read a head slot byte, or no-op.
// Output channel (out_*): exactly one result beat per input beat, in order,
// carrying the read byte, ring flags, frame event, decoded head header,
// fill and head slot numbers and the running checksum.
// Frames open with 0x7E, 0x7D escapes the following byte, and a frame whose
// checksum totals 0xFF is committed to the ring.
// Throughput: one beat per cycle while in_tready is high.
// The edge that takes a beat updates the state and makes at most one packet
// memory access; the result then goes through the queue and output register.
// A four-entry queue decouples the deframer from the output register; when
// the receiver stalls the queue fills and in_tready drops, with no beat lost.
// Reset: ring empty, no packet ready, deframer hunts for a delimiter.
// Packet memory is not cleared; only committed bytes are ever read back.
`default_nettype none

module api_frame_receiver_packet_ring #(
  parameter int SLOT_BYTES = 128,
  parameter int SLOT_COUNT = 4,
  localparam int SW = $clog2(SLOT_COUNT),
  localparam int OUT_W = apfr_pkg::out_width(SW)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [15:0]      in_tdata,   // rx_byte[7:0], read_index[14:8]
  input  wire logic [1:0]       in_tuser,   // func[1:0]
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // read_data, pkt_ready, ring_full, frame_event, head_identifier,
  // head_src_addr, head_rssi, head_data_len, head_pkt_len, write_slot,
  // read_slot, running_sum
  output logic [OUT_W-1:0]      out_tdata
);
  import apfr_pkg::*;

  localparam int Q_W = $bits(apfr_info_t) + 2 * SW;

  logic b_valid;
  apfr_info_t b_info;
  logic [SW-1:0] b_fill_slot, b_head_slot;
  logic q_afull, q_valid, q_pop;
  logic [Q_W-1:0] q_rdata;
  apfr_info_t q_info;
  logic [SW-1:0] q_fill_slot, q_head_slot;

  // Deframe, update the ring and access the packet memory.
  apfr_front #(
    .SLOT_BYTES(SLOT_BYTES),
    .SLOT_COUNT(SLOT_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .func       (apfr_func_t'(in_tuser)),
    .rx_byte    (in_tdata[7:0]),
    .read_index (in_tdata[14:8]),
    .q_afull    (q_afull),
    .b_valid    (b_valid),
    .b_info     (b_info),
    .b_fill_slot(b_fill_slot),
    .b_head_slot(b_head_slot)
  );

  // Buffer beats so the deframer keeps going while the output stalls.
  apfr_fifo #(
    .W    (Q_W),
    .DEPTH(Q_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (b_valid),
    .wdata({b_head_slot, b_fill_slot, b_info}),
    .pop  (q_pop),
    .valid(q_valid),
    .rdata(q_rdata),
    .afull(q_afull)
  );

  assign q_info      = apfr_info_t'(q_rdata[$bits(apfr_info_t)-1:0]);
  assign q_fill_slot = q_rdata[$bits(apfr_info_t) +: SW];
  assign q_head_slot = q_rdata[$bits(apfr_info_t) + SW +: SW];

  // Decode the head header and drive the output register.
  apfr_back #(
    .SW(SW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_info     (q_info),
    .q_fill_slot(q_fill_slot),
    .q_head_slot(q_head_slot),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata)
  );

endmodule

`default_nettype wire

// ----- rtl/core/apfr_checker.sv -----
`default_nettype none

module apfr_props #(
  parameter int OUT_W = 80
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);
  import apfr_pkg::*;

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  // A full ring always has a packet ready.
  a_full_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> out_tdata[8])
    else $error("ring_full without pkt_ready");

  // With no packet waiting, head fields and read data are zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[8] |-> out_tdata[60:12] == '0 && out_tdata[7:0] == '0)
    else $error("head fields nonzero with no packet ready");

  // An accepted frame leaves a packet ready.
  a_accept_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11:10] == EV_ACCEPT |-> out_tdata[8])
    else $error("frame accepted but no packet ready");

endmodule

bind api_frame_receiver_packet_ring apfr_props #(
  .OUT_W($bits(out_tdata))
) u_apfr_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

`default_nettype wire
